// ===== rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, types and the reciprocal table for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int CfgDataW   = 13;
  localparam int PixW       = 24;
  localparam int SumW       = 12;
  localparam int CntW       = 4;
  localparam int RecipW     = 20;
  localparam int RecipShift = 20;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [SumW-1:0] sum_t;
  typedef logic [CntW-1:0] cnt_t;

  // ceil(2^20 / (2*n)) for the neighbor counts that can occur
  function automatic logic [RecipW-1:0] recip(input cnt_t n);
    logic [RecipW-1:0] r;
    begin
      case (n)
        4'd1:    r = 20'd524288;
        4'd2:    r = 20'd262144;
        4'd3:    r = 20'd174763;
        4'd4:    r = 20'd131072;
        4'd6:    r = 20'd87382;
        4'd9:    r = 20'd58255;
        default: r = 20'd524288;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_clipped_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_top
// A new pixel is accepted only in the idle state: the line store read/write-back
// and the sum/mean pass, done one result at a time, must finish for all results
// of a pixel before the next pixel is taken.
// Reset: positions and window clear, size registers go to 640x480; line store
// is not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bb3_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  output logic [11:0]                   out_row_o,
  output logic [9:0]                    out_col_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o
);
  import bb3_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [ColW-1:0]       col_q;
  logic [HeightRegW-1:0] row_q;
  logic [ColW-1:0]       cur_c_q;
  logic [HeightRegW-1:0] cur_r_q;
  pix_t                  px_q;
  pix_t                  win_q [3][3];
  logic [3:0]            pend_q;
  sum_t                  sum_q [3];
  cnt_t                  cnt_q;
  logic [HeightRegW-1:0] res_r_q;
  logic [ColW-1:0]       res_c_q;
  logic                  res_last_q, res_done_q;
  logic                  out_valid_q;
  logic [7:0]            red_q, green_q, blue_q;
  logic [11:0]           out_row_q;
  logic [9:0]            out_col_q;
  logic                  last_q, done_q;

  logic [WidthRegW-1:0]  w_eff;
  logic [HeightRegW-1:0] h_eff;
  logic [ColW-1:0]       c_eff;
  logic [HeightRegW-1:0] r_eff;
  logic                  accept;
  logic [2*PixW-1:0]     rd_data;
  logic                  c_last, r_last;
  logic [3:0]            sel;
  logic                  pr_top, pc_left;
  logic [2:0]            row_ok, col_ok;
  sum_t                  sum_d [3];
  cnt_t                  cnt_d;
  logic [7:0]            mean [3];
  logic                  load_out;

  assign w_eff = (width_q == '0) ? WidthRegW'(1) :
                 (width_q > WidthRegW'(MaxWidth)) ? WidthRegW'(MaxWidth) : width_q;
  assign h_eff = (height_q == '0) ? HeightRegW'(1) : height_q;
  assign c_eff = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
  assign r_eff = (row_q >= h_eff) ? '0 : row_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign c_last = ({1'b0, cur_c_q} == w_eff - WidthRegW'(1));
  assign r_last = (cur_r_q == h_eff - HeightRegW'(1));

  bb3_line_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_eff),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == S_RD),
    .wr_addr_i (cur_c_q),
    .wr_data_i ({rd_data[PixW-1:0], px_q})
  );

  // next pending result: lowest set flag
  always_comb begin
    sel = 4'b0000;
    case (1'b1)
      pend_q[0]: sel = 4'b0001;
      pend_q[1]: sel = 4'b0010;
      pend_q[2]: sel = 4'b0100;
      pend_q[3]: sel = 4'b1000;
      default:   sel = 4'b0000;
    endcase
  end

  assign pr_top  = sel[0] | sel[2];
  assign pc_left = sel[0] | sel[1];

  assign row_ok[0] = pr_top && (cur_r_q >= HeightRegW'(2));
  assign row_ok[1] = (cur_r_q >= HeightRegW'(1));
  assign row_ok[2] = 1'b1;
  assign col_ok[0] = pc_left && (cur_c_q >= ColW'(2));
  assign col_ok[1] = (cur_c_q >= ColW'(1));
  assign col_ok[2] = 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = '0;
    end
    cnt_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          sum_d[0] = sum_d[0] + SumW'(win_q[i][j][23:16]);
          sum_d[1] = sum_d[1] + SumW'(win_q[i][j][15:8]);
          sum_d[2] = sum_d[2] + SumW'(win_q[i][j][7:0]);
          cnt_d    = cnt_d + CntW'(1);
        end
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_mean
    bb3_mean u_mean (
      .sum_i  (sum_q[g]),
      .cnt_i  (cnt_q),
      .mean_o (mean[g])
    );
  end

  assign load_out = (state_q == S_DIV) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_RD:   state_d = S_SUM;
      S_SUM:  state_d = (pend_q == '0) ? S_IDLE : S_DIV;
      S_DIV: begin
        if (load_out) begin
          state_d = ((pend_q & ~sel) == '0) ? S_IDLE : S_SUM;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WidthRegW'(640);
      height_q    <= HeightRegW'(480);
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) begin
          width_q <= cfg_data_i[WidthRegW-1:0];
        end else begin
          height_q <= cfg_data_i;
        end
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if ({1'b0, c_eff} + WidthRegW'(1) >= w_eff) begin
          col_q <= '0;
          row_q <= (r_eff + HeightRegW'(1) >= h_eff) ? '0 : r_eff + HeightRegW'(1);
        end else begin
          col_q <= c_eff + ColW'(1);
          row_q <= r_eff;
        end
      end
      if (state_q == S_RD) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= rd_data[2*PixW-1:PixW];
        win_q[1][2] <= rd_data[PixW-1:0];
        win_q[2][2] <= px_q;
        pend_q <= {c_last && r_last,
                   c_last && (cur_r_q != '0),
                   (cur_c_q != '0) && r_last,
                   (cur_c_q != '0) && (cur_r_q != '0)};
      end else if (load_out) begin
        pend_q <= pend_q & ~sel;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= {red_in_i, green_in_i, blue_in_i};
      cur_c_q <= c_eff;
      cur_r_q <= r_eff;
    end
    if (state_q == S_SUM) begin
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      res_r_q    <= pr_top ? cur_r_q - HeightRegW'(1) : cur_r_q;
      res_c_q    <= pc_left ? cur_c_q - ColW'(1) : cur_c_q;
      res_last_q <= ((pend_q & ~sel) == '0);
      res_done_q <= !pr_top && !pc_left && r_last && c_last;
    end
    if (load_out) begin
      red_q     <= mean[0];
      green_q   <= mean[1];
      blue_q    <= mean[2];
      out_row_q <= res_r_q[11:0];
      out_col_q <= res_c_q;
      last_q    <= res_last_q;
      done_q    <= res_done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_out_o     = red_q;
  assign green_out_o   = green_q;
  assign blue_out_o    = blue_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign last_of_run_o = last_q;
  assign frame_done_o  = done_q;

endmodule

// ===== rtl/bb3_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_ram
// Two-row line store, one entry per column holding both rows above.
// ----------------------------------------------------------------------------
module bb3_line_ram (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [bb3_pkg::ColW-1:0]  rd_addr_i,
  output logic [2*bb3_pkg::PixW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [bb3_pkg::ColW-1:0]  wr_addr_i,
  input  logic [2*bb3_pkg::PixW-1:0] wr_data_i
);
  import bb3_pkg::*;

  logic [2*PixW-1:0] mem [MaxWidth];
  logic [2*PixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bb3_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_mean
// Rounded mean floor((2*sum+n)/(2*n)) by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bb3_mean (
  input  bb3_pkg::sum_t sum_i,
  input  bb3_pkg::cnt_t cnt_i,
  output logic [7:0]    mean_o
);
  import bb3_pkg::*;

  logic [SumW:0]               num;
  logic [SumW+RecipW:0]        prod;

  assign num    = {sum_i, 1'b0} + {{(SumW+1-CntW){1'b0}}, cnt_i};
  assign prod   = {{RecipW{1'b0}}, num} * {{(SumW+1){1'b0}}, recip(cnt_i)};
  assign mean_o = prod[RecipShift+7:RecipShift];

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - 3x3 edge-clipped box blur testbench
// Streams RGB frames of assorted sizes, including the clamped size extremes,
// through the blur with random stalls on both sides. Every result beat is
// compared field by field with an in-order queue filled by a predictor of
// the blur. A short directed table runs first, then random frames.
// ----------------------------------------------------------------------------
module tb;
  import bb3_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
    logic        done;
  } blur_res_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic            idx;
    logic [12:0]     data;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            typed;
    blur_res_t       res;
  } dir_row_t;

  localparam int NumDir = 25;
  localparam int RandItems = 310;
  localparam int SettleCycles = 20;

  localparam blur_res_t NoRes = '0;

  dir_row_t dir_tbl [NumDir] = '{
    '{ROW_CFG, CFG_WIDTH,  13'd1,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_CFG, CFG_HEIGHT, 13'd1,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'hff, 8'h00, 8'hff, 1'b1,
      '{8'hff, 8'h00, 8'hff, 12'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h00, 8'hff, 8'h00, 1'b1,
      '{8'h00, 8'hff, 8'h00, 12'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h00, 8'h00, 8'h00, 1'b1,
      '{8'h00, 8'h00, 8'h00, 12'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_WIDTH,  13'd0,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_CFG, CFG_HEIGHT, 13'd0,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h12, 8'h34, 8'h56, 1'b1,
      '{8'h12, 8'h34, 8'h56, 12'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_WIDTH,  13'd2047, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_CFG, CFG_HEIGHT, 13'd1,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'hff, 8'hff, 8'hff, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'hff, 8'h01, 8'h80, 1'b0, NoRes},
    '{ROW_CFG, CFG_WIDTH,  13'd3,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_CFG, CFG_HEIGHT, 13'd2,    8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'hff, 8'h00, 8'h10, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h00, 8'hff, 8'h20, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'hff, 8'h00, 8'h30, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h00, 8'hff, 8'h40, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'hff, 8'h00, 8'h50, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h00, 8'hff, 8'h60, 1'b0, NoRes},
    '{ROW_CFG, CFG_HEIGHT, 13'd8191, 8'h00, 8'h00, 8'h00, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h01, 8'h02, 8'h04, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h08, 8'h10, 8'h20, 1'b0, NoRes},
    '{ROW_PIX, CFG_WIDTH,  13'd0,    8'h40, 8'h80, 8'hfe, 1'b0, NoRes}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = CFG_WIDTH;
  logic [12:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        red_in = '0;
  logic [7:0]        green_in = '0;
  logic [7:0]        blue_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        red_out;
  logic [7:0]        green_out;
  logic [7:0]        blue_out;
  logic [11:0]       out_row;
  logic [9:0]        out_col;
  logic              last_of_run;
  logic              frame_done;

  box_blur_3x3_edge_clipped_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .last_of_run_o (last_of_run),
    .frame_done_o  (frame_done)
  );

  // predictor state
  logic [10:0] width_reg = 11'd640;
  logic [12:0] height_reg = 13'd480;
  pix_t        row_mem [2][MaxWidth];
  pix_t        win [3][3];
  int          cur_col = 0;
  int          cur_row = 0;

  blur_res_t   pending_blur [$];
  int          mismatches = 0;
  int          pixels_sent = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  bit          no_idle = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

  function automatic blur_res_t blur_at(int pr, int pc, int cr, int cc, int w, int h);
    blur_res_t res;
    int s_r, s_g, s_b, n, fr, fc;
    pix_t px;
    s_r = 0; s_g = 0; s_b = 0; n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      fr = pr + dr;
      if (fr < 0 || fr >= h || fr > cr || fr < cr - 2) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        fc = pc + dc;
        if (fc < 0 || fc >= w || fc > cc || fc < cc - 2) continue;
        px = win[fr - (cr - 2)][fc - (cc - 2)];
        s_r += px[23:16];
        s_g += px[15:8];
        s_b += px[7:0];
        n++;
      end
    end
    if (n == 0) n = 1;
    res.red   = 8'((2 * s_r + n) / (2 * n));
    res.green = 8'((2 * s_g + n) / (2 * n));
    res.blue  = 8'((2 * s_b + n) / (2 * n));
    res.row   = 12'(pr);
    res.col   = 10'(pc);
    res.last  = 1'b0;
    res.done  = (pr == h - 1 && pc == w - 1);
    return res;
  endfunction

  task automatic predict_blur(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic typed, input blur_res_t typed_res);
    int w, h, c, rw;
    blur_res_t outs [$];
    pix_t px;
    w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
    h = (height_reg == 0) ? 1 : int'(height_reg);
    c = (cur_col >= w) ? 0 : cur_col;
    rw = (cur_row >= h) ? 0 : cur_row;
    px = {r, g, b};
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = row_mem[0][c];
    win[1][2] = row_mem[1][c];
    win[2][2] = px;
    row_mem[0][c] = row_mem[1][c];
    row_mem[1][c] = px;
    if (c >= 1) begin
      if (rw >= 1) outs.push_back(blur_at(rw - 1, c - 1, rw, c, w, h));
      if (rw == h - 1) outs.push_back(blur_at(rw, c - 1, rw, c, w, h));
    end
    if (c == w - 1) begin
      if (rw >= 1) outs.push_back(blur_at(rw - 1, c, rw, c, w, h));
      if (rw == h - 1) outs.push_back(blur_at(rw, c, rw, c, w, h));
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    if (typed) begin
      pending_blur.push_back(typed_res);
    end else begin
      foreach (outs[i]) pending_blur.push_back(outs[i]);
    end
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (rw + 1 >= h) ? 0 : rw + 1;
    end else begin
      cur_col = c + 1;
      cur_row = rw;
    end
  endtask

  // wait for all results, then let in-flight row-0 pixels settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [12:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WIDTH) width_reg = val[10:0];
    else height_reg = val;
    cur_col = 0;
    cur_row = 0;
    cfg_writes++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic typed, input blur_res_t typed_res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (!in_ready);
    predict_blur(r, g, b, typed, typed_res);
    pixels_sent++;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // result side
  initial begin
    blur_res_t got, exp_res;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{red_out, green_out, blue_out, out_row, out_col, last_of_run, frame_done};
      results_seen++;
      if (pending_blur.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_res = pending_blur.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_res, got);
        end
      end
    end
  end

  initial begin
    int w, h, n_items;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < MaxWidth; j++) row_mem[i][j] = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        drain_results();
        write_cfg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        send_pixel(dir_tbl[i].red, dir_tbl[i].green, dir_tbl[i].blue,
                   dir_tbl[i].typed, dir_tbl[i].res);
      end
    end

    while (pixels_sent < RandItems) begin
      drain_results();
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin w = 2047; h = 1; end
        1: begin w = 0; h = $urandom_range(0, 3); end
        2: begin w = $urandom_range(1, 6); h = 8191; end
        default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 6); end
      endcase
      if ($urandom_range(0, 1)) begin
        write_cfg(CFG_WIDTH, 13'(w));
        write_cfg(CFG_HEIGHT, 13'(h));
      end else begin
        write_cfg(CFG_HEIGHT, 13'(h));
        write_cfg(CFG_WIDTH, 13'(w));
      end
      if (w >= MaxWidth || h > 6) begin
        n_items = $urandom_range(10, 40);
      end else begin
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        case ($urandom_range(0, 3))
          0: n_items = $urandom_range(1, w * h);
          1: n_items = w * h + $urandom_range(1, w * h);
          default: n_items = w * h;
        endcase
      end
      repeat (n_items) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, NoRes);
    end

    drain_results();
    $display("%0d pixels over %0d register writes, %0d result beats checked",
             pixels_sent, cfg_writes, results_seen);
    $display("frame sizes from 1x1 to clamped 1024-wide and 8191-high, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
